>>> rtl/vector_mask_unit_defines.svh
// Assertion macros for the vector mask unit.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef VECTOR_MASK_UNIT_DEFINES_SVH
`define VECTOR_MASK_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VMU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VMU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vmu_pkg.sv
// Shared types and constants of the vector mask unit.
// No dependencies; imported by the interfaces, the lane, the merge stage and the top level.
package vmu_pkg;

    localparam int FIELD_W       = 64;
    localparam int MODE_W        = 4;
    localparam int CHUNK_NUM_W   = 4;
    localparam int SCALAR_W      = 12;
    localparam int VL_W          = 11;

    localparam int CHUNK_BITS    = 64;
    localparam int MAX_MASK_BITS = 1024;
    localparam int LANES         = 4;

    localparam int LANE_BITS     = CHUNK_BITS / LANES;
    localparam int LANE_OFF_W    = $clog2(LANE_BITS);
    localparam int LANE_CNT_W    = $clog2(LANE_BITS) + 1;
    localparam int CHUNK_W       = $clog2(CHUNK_BITS);
    localparam int SUM_W         = CHUNK_W + 1;
    localparam int BASE_W        = CHUNK_NUM_W + CHUNK_W;
    localparam int COUNT_W       = $clog2(MAX_MASK_BITS) + 1;
    localparam int DIFF_W        = ((COUNT_W > BASE_W) ? COUNT_W : BASE_W) + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_AND   = 4'd0,
        MODE_NAND  = 4'd1,
        MODE_ANDN  = 4'd2,
        MODE_OR    = 4'd3,
        MODE_NOR   = 4'd4,
        MODE_ORN   = 4'd5,
        MODE_XOR   = 4'd6,
        MODE_XNOR  = 4'd7,
        MODE_POPC  = 4'd8,
        MODE_FIRST = 4'd9
    } t_mode;

    // What one lane found in its slice of the chunk.
    typedef struct packed {
        logic [LANE_BITS-1:0]  dest;
        logic [LANE_CNT_W-1:0] count;
        logic                  hit;
        logic [LANE_OFF_W-1:0] first;
    } t_lane_res;

    // Request control carried next to the lane results.
    typedef struct packed {
        t_mode                  mode;
        logic                   last;
        logic [CHUNK_NUM_W-1:0] chunk;
    } t_req_info;

    typedef struct packed {
        logic [FIELD_W-1:0]         dest;
        logic signed [SCALAR_W-1:0] scalar;
        logic                       scalar_ready;
    } t_result;

    function automatic logic is_logical(t_mode m);
        return m <= MODE_XNOR;
    endfunction

endpackage

>>> rtl/vmu_if.sv
// Handshake channels of the vector mask unit: request, response, config.
// Depends on vmu_pkg for field widths.
interface vmu_in_if
    import vmu_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [FIELD_W-1:0]     first_chunk;
    logic [FIELD_W-1:0]     second_chunk;
    logic [FIELD_W-1:0]     mask_chunk;
    logic [FIELD_W-1:0]     old_dest_chunk;
    logic                   unmasked;
    logic [CHUNK_NUM_W-1:0] chunk_number;
    logic                   last_chunk;

    modport source (output valid, mode, first_chunk, second_chunk, mask_chunk,
                    old_dest_chunk, unmasked, chunk_number, last_chunk,
                    input ready);
    modport sink (input valid, mode, first_chunk, second_chunk, mask_chunk,
                  old_dest_chunk, unmasked, chunk_number, last_chunk,
                  output ready);
endinterface

interface vmu_out_if
    import vmu_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [FIELD_W-1:0]         dest_chunk;
    logic signed [SCALAR_W-1:0] scalar_value;
    logic                       scalar_ready;

    modport source (output valid, dest_chunk, scalar_value, scalar_ready, input ready);
    modport sink (input valid, dest_chunk, scalar_value, scalar_ready, output ready);
endinterface

interface vmu_cfg_if
    import vmu_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [VL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> rtl/vmu_lane.sv
// One lane: logical op, tail merge, popcount and first-set search on a slice.
// Depends on vmu_pkg.
module vmu_lane
    import vmu_pkg::*;
(
    input  t_mode                 i_mode,
    input  logic [LANE_BITS-1:0]  i_a,
    input  logic [LANE_BITS-1:0]  i_b,
    input  logic [LANE_BITS-1:0]  i_v0,
    input  logic [LANE_BITS-1:0]  i_old,
    input  logic                  i_unmasked,
    input  logic [BASE_W-1:0]     i_base,
    input  logic [COUNT_W-1:0]    i_vl,
    output t_lane_res             o_res
);

    logic [DIFF_W-1:0]     diff;
    logic                  any_active;
    logic [LANE_BITS-1:0]  act;
    logic [LANE_BITS-1:0]  op;
    logic [LANE_BITS-1:0]  src;
    logic [LANE_CNT_W-1:0] cnt;
    logic [LANE_OFF_W-1:0] first;

    // Bit j is active when base + j < vl.
    always_comb begin
        any_active = DIFF_W'(i_vl) > DIFF_W'(i_base);
        diff       = DIFF_W'(i_vl) - DIFF_W'(i_base);
        for (int j = 0; j < LANE_BITS; j++) begin
            act[j] = any_active && (diff > DIFF_W'(j));
        end
    end

    always_comb begin
        case (i_mode)
            MODE_AND:  op = i_a & i_b;
            MODE_NAND: op = ~(i_a & i_b);
            MODE_ANDN: op = ~i_a & i_b;
            MODE_OR:   op = i_a | i_b;
            MODE_NOR:  op = ~(i_a | i_b);
            MODE_ORN:  op = ~i_a | i_b;
            MODE_XOR:  op = i_a ^ i_b;
            MODE_XNOR: op = ~(i_a ^ i_b);
            default:   op = '0;
        endcase
    end

    assign src = i_b & act & (i_unmasked ? {LANE_BITS{1'b1}} : i_v0);

    always_comb begin
        cnt   = '0;
        first = '0;
        for (int j = 0; j < LANE_BITS; j++) begin
            cnt = cnt + LANE_CNT_W'(src[j]);
        end
        for (int j = LANE_BITS - 1; j >= 0; j--) begin
            if (src[j]) begin
                first = LANE_OFF_W'(j);
            end
        end
    end

    assign o_res.dest  = (op & act) | (i_old & ~act);
    assign o_res.count = cnt;
    assign o_res.hit   = |src;
    assign o_res.first = first;

endmodule

>>> rtl/vmu_merge.sv
// Merge stage: sums lane counts, picks the first hit lane, keeps the running
// popcount / find-first state and forms the response. Depends on vmu_pkg.
module vmu_merge
    import vmu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  t_req_info              i_info,
    input  t_lane_res [LANES-1:0]  i_lanes,
    output logic                   o_emit,
    output t_result                o_result
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_found, n_found;
    logic [BASE_W-1:0]  r_pos,   n_pos;

    logic [SUM_W-1:0]      sum;
    logic                  any_hit;
    logic [BASE_W-1:0]     hit_pos;
    logic [CHUNK_BITS-1:0] dest;
    logic [COUNT_W:0]      raw_count;
    logic [COUNT_W-1:0]    sat_count;
    logic                  find_now;

    always_comb begin
        sum     = '0;
        any_hit = 1'b0;
        hit_pos = '0;
        for (int l = 0; l < LANES; l++) begin
            sum = sum + SUM_W'(i_lanes[l].count);
            dest[l*LANE_BITS +: LANE_BITS] = i_lanes[l].dest;
        end
        // lowest lane with a hit wins
        for (int l = LANES - 1; l >= 0; l--) begin
            if (i_lanes[l].hit) begin
                any_hit = 1'b1;
                hit_pos = (BASE_W'(i_info.chunk) << CHUNK_W)
                        | (BASE_W'(l) << LANE_OFF_W)
                        | BASE_W'(i_lanes[l].first);
            end
        end
    end

    always_comb begin
        raw_count = (COUNT_W+1)'(r_count) + (COUNT_W+1)'(sum);
        sat_count = (raw_count > (COUNT_W+1)'(MAX_MASK_BITS)) ?
                    COUNT_W'(MAX_MASK_BITS) : raw_count[COUNT_W-1:0];
        find_now  = !r_found && any_hit;
    end

    always_comb begin
        o_emit              = is_logical(i_info.mode) ||
                              ((i_info.mode == MODE_POPC || i_info.mode == MODE_FIRST)
                               && i_info.last);
        o_result.dest         = '0;
        o_result.scalar       = '0;
        o_result.scalar_ready = 1'b0;
        if (is_logical(i_info.mode)) begin
            o_result.dest = FIELD_W'(dest);
        end else if (i_info.mode == MODE_POPC) begin
            o_result.scalar       = SCALAR_W'(sat_count);
            o_result.scalar_ready = 1'b1;
        end else if (i_info.mode == MODE_FIRST) begin
            if (r_found) begin
                o_result.scalar = SCALAR_W'(r_pos);
            end else if (any_hit) begin
                o_result.scalar = SCALAR_W'(hit_pos);
            end else begin
                o_result.scalar = '1;
            end
            o_result.scalar_ready = 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        n_found = r_found;
        n_pos   = r_pos;
        if (i_fire) begin
            if (i_info.mode == MODE_POPC) begin
                n_count = sat_count;
            end
            if (i_info.mode == MODE_FIRST && find_now) begin
                n_found = 1'b1;
                n_pos   = hit_pos;
            end
            if (i_info.last) begin
                n_count = '0;
                n_found = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_count <= n_count;
            r_found <= n_found;
            r_pos   <= n_pos;
        end
    end

endmodule

>>> rtl/vector_mask_unit.sv
// Vector mask unit: runs mask logical ops, popcount and find-first over a
// mask register streamed in 64-bit chunks.
// Channels: i_cfg writes vector_length (always ready); i_req takes one
// chunk request per cycle while ready; o_rsp returns one response per
// logical-op chunk, and one scalar response on the last chunk of a
// popcount or find-first. A response passes the lane-stage register, then
// the output register.
// Throughput: one request per cycle while i_req.ready is high. Four lanes
// of 16 bits each evaluate a chunk; the merge stage adds the lane counts and
// picks the first hit, so running state is updated with no bubble.
// Stall: while o_rsp is held, a request that makes no response still moves
// on; one that makes a response waits in the lane stage and i_req.ready
// drops only when that stage is also occupied.
// Reset (synchronous, active low): clears vector_length, the running count,
// the found flag and both valid flags. Write vector_length only when idle.
// Depends on vmu_pkg, vmu_if, vmu_lane, vmu_merge, vector_mask_unit_defines.
`include "vector_mask_unit_defines.svh"

module vector_mask_unit
    import vmu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    vmu_cfg_if.sink   i_cfg,
    vmu_in_if.sink    i_req,
    vmu_out_if.source o_rsp
);

    logic [VL_W-1:0]    r_vl;
    logic [COUNT_W-1:0] vl_eff;

    logic                  r_s1_valid, n_s1_valid;
    t_req_info             r_s1_info;
    t_lane_res [LANES-1:0] r_s1_lanes;
    t_lane_res [LANES-1:0] lane_res;

    logic    r_out_valid, n_out_valid;
    t_result r_out;
    t_result merge_res;
    logic    s1_emit;
    logic    out_free, s1_move, req_accept;

    // ---------------- configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl <= '0;
        end else if (i_cfg.valid) begin
            r_vl <= i_cfg.data;
        end
    end

    assign vl_eff = (VL_W'(MAX_MASK_BITS) < r_vl) ? COUNT_W'(MAX_MASK_BITS)
                                                   : COUNT_W'(r_vl);

    // ---------------- lanes
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        vmu_lane u_lane (
            .i_mode     (t_mode'(i_req.mode)),
            .i_a        (i_req.first_chunk[l*LANE_BITS +: LANE_BITS]),
            .i_b        (i_req.second_chunk[l*LANE_BITS +: LANE_BITS]),
            .i_v0       (i_req.mask_chunk[l*LANE_BITS +: LANE_BITS]),
            .i_old      (i_req.old_dest_chunk[l*LANE_BITS +: LANE_BITS]),
            .i_unmasked (i_req.unmasked),
            .i_base     ((BASE_W'(i_req.chunk_number) << CHUNK_W)
                         | (BASE_W'(l) << LANE_OFF_W)),
            .i_vl       (vl_eff),
            .o_res      (lane_res[l])
        );
    end

    // ---------------- pipeline control
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign s1_move     = r_s1_valid && (out_free || !s1_emit);
    assign i_req.ready = !r_s1_valid || s1_move;
    assign req_accept  = i_req.valid && i_req.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (req_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_move && s1_emit) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_s1_info.mode  <= t_mode'(i_req.mode);
            r_s1_info.last  <= i_req.last_chunk;
            r_s1_info.chunk <= i_req.chunk_number;
            r_s1_lanes      <= lane_res;
        end
        if (s1_move && s1_emit) begin
            r_out <= merge_res;
        end
    end

    // ---------------- merge
    vmu_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_move),
        .i_info   (r_s1_info),
        .i_lanes  (r_s1_lanes),
        .o_emit   (s1_emit),
        .o_result (merge_res)
    );

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.dest_chunk   = r_out.dest;
    assign o_rsp.scalar_value = r_out.scalar;
    assign o_rsp.scalar_ready = r_out.scalar_ready;

    // ---------------- checks
    `VMU_ASSERT_NEXT(a_accept_fills_s1, req_accept, r_s1_valid, "accepted request lost")
    `VMU_ASSERT_NOW(a_full_blocks_req,
        r_s1_valid && s1_emit && r_out_valid && !o_rsp.ready, !i_req.ready,
        "request taken while both stages are blocked")
    `VMU_ASSERT_NOW(a_logic_rsp_no_scalar,
        r_out_valid && !r_out.scalar_ready, r_out.scalar == '0,
        "logical response carries a scalar")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for vector_mask_unit: bitwise mask ops, popcount and
// find-first over streamed 64-bit chunks, checked against an in-bench predictor.
// Depends on vmu_pkg, the vmu_*_if interfaces and the vector_mask_unit RTL.
module testbench;
    import vmu_pkg::*;

    localparam int IDLE_MAX      = 13;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASE  = 60;
    localparam logic [MODE_W-1:0] MODE_TOP = '1;

    typedef struct {
        logic [MODE_W-1:0]      mode;
        logic [FIELD_W-1:0]     vs1;
        logic [FIELD_W-1:0]     vs2;
        logic [FIELD_W-1:0]     v0;
        logic [FIELD_W-1:0]     old_dest;
        logic                   unmasked;
        logic [CHUNK_NUM_W-1:0] chunk;
        logic                   last;
    } t_mask_req;

    logic clk;
    logic rst_n;

    vmu_cfg_if cfg_ch ();
    vmu_in_if  req_ch ();
    vmu_out_if rsp_ch ();

    vector_mask_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // predictor state
    logic [VL_W-1:0]  active_len;
    int unsigned      pop_total;
    bit               first_found;
    int unsigned      first_pos;

    t_result     awaited_responses[$];
    int unsigned mismatch_count;
    int unsigned requests_sent;
    int unsigned responses_checked;
    int unsigned settings_used;
    int unsigned cycle_count;
    int unsigned rsp_gap;
    bit          idle_on;
    bit          hold_ask;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, awaited_responses.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned draw_idle();
        return idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    endfunction

    // Works out the response a request causes, if any, and advances the state.
    function automatic bit compute_mask_response(input t_mask_req r, output t_result res);
        logic [FIELD_W-1:0] act;
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] raw;
        int unsigned eff_len;
        int unsigned base;
        int unsigned total;
        int unsigned pos;
        bit produced;
        produced = 1'b0;
        res = '0;
        raw = '0;
        pos = 0;
        eff_len = (active_len > MAX_MASK_BITS) ? MAX_MASK_BITS : active_len;
        base = int'(r.chunk) * CHUNK_BITS;
        if (eff_len <= base) begin
            act = '0;
        end else if (eff_len - base >= CHUNK_BITS) begin
            act = '1;
        end else begin
            act = (64'd1 << (eff_len - base)) - 64'd1;
        end

        if (r.mode <= MODE_XNOR) begin
            case (r.mode)
                MODE_AND:  raw = r.vs1 & r.vs2;
                MODE_NAND: raw = ~(r.vs1 & r.vs2);
                MODE_ANDN: raw = ~r.vs1 & r.vs2;
                MODE_OR:   raw = r.vs1 | r.vs2;
                MODE_NOR:  raw = ~(r.vs1 | r.vs2);
                MODE_ORN:  raw = ~r.vs1 | r.vs2;
                MODE_XOR:  raw = r.vs1 ^ r.vs2;
                default:   raw = ~(r.vs1 ^ r.vs2);
            endcase
            res.dest = (raw & act) | (r.old_dest & ~act);
            produced = 1'b1;
        end else if (r.mode == MODE_POPC || r.mode == MODE_FIRST) begin
            src = r.vs2 & act;
            if (!r.unmasked) src &= r.v0;
            if (r.mode == MODE_POPC) begin
                total = pop_total + $countones(src);
                pop_total = (total > MAX_MASK_BITS) ? MAX_MASK_BITS : total;
                if (r.last) begin
                    res.scalar = SCALAR_W'(pop_total);
                    res.scalar_ready = 1'b1;
                    produced = 1'b1;
                end
            end else begin
                if (!first_found && src != '0) begin
                    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
                        if (src[i]) pos = i;
                    end
                    first_found = 1'b1;
                    first_pos = base + pos;
                end
                if (r.last) begin
                    res.scalar = first_found ? SCALAR_W'(first_pos) : '1;
                    res.scalar_ready = 1'b1;
                    produced = 1'b1;
                end
            end
        end

        // any last chunk ends the instruction
        if (r.last) begin
            pop_total = 0;
            first_found = 1'b0;
        end
        return produced;
    endfunction

    // Response side: random stalls, plus one long hold-off when asked.
    always @(posedge clk) begin
        if (hold_ask) begin
            hold_ask <= 1'b0;
            rsp_gap = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else if (rsp_gap != 0) begin
            rsp_gap--;
            if (rsp_gap == 0) rsp_ch.ready <= 1'b1;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_gap = draw_idle();
            if (rsp_gap != 0) rsp_ch.ready <= 1'b0;
        end
    end

    always @(posedge clk) begin
        t_result exp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            responses_checked++;
            if (awaited_responses.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected response dest %h scalar %0d ready %b", $time,
                         rsp_ch.dest_chunk, rsp_ch.scalar_value, rsp_ch.scalar_ready);
            end else begin
                exp = awaited_responses.pop_front();
                if (rsp_ch.dest_chunk !== exp.dest) begin
                    mismatch_count++;
                    $display("%0t: dest_chunk expected %h got %h", $time, exp.dest,
                             rsp_ch.dest_chunk);
                end
                if (rsp_ch.scalar_value !== exp.scalar) begin
                    mismatch_count++;
                    $display("%0t: scalar_value expected %0d got %0d", $time, exp.scalar,
                             rsp_ch.scalar_value);
                end
                if (rsp_ch.scalar_ready !== exp.scalar_ready) begin
                    mismatch_count++;
                    $display("%0t: scalar_ready expected %b got %b", $time,
                             exp.scalar_ready, rsp_ch.scalar_ready);
                end
            end
        end
    end

    function automatic t_mask_req make_request(input logic [MODE_W-1:0] mode,
                                               input logic [FIELD_W-1:0] vs1,
                                               input logic [FIELD_W-1:0] vs2,
                                               input logic [FIELD_W-1:0] v0,
                                               input logic [FIELD_W-1:0] old_dest,
                                               input logic unmasked,
                                               input logic [CHUNK_NUM_W-1:0] chunk,
                                               input logic last);
        t_mask_req r;
        r.mode = mode;
        r.vs1 = vs1;
        r.vs2 = vs2;
        r.v0 = v0;
        r.old_dest = old_dest;
        r.unmasked = unmasked;
        r.chunk = chunk;
        r.last = last;
        return r;
    endfunction

    // Mix of edge patterns and fully random words.
    function automatic logic [FIELD_W-1:0] rand_word();
        logic [FIELD_W-1:0] one_hot;
        one_hot = 64'd1 << $urandom_range(0, FIELD_W - 1);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_mask_request(input t_mask_req r);
        int unsigned gap;
        t_result res;
        gap = draw_idle();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.mode           <= r.mode;
        req_ch.first_chunk    <= r.vs1;
        req_ch.second_chunk   <= r.vs2;
        req_ch.mask_chunk     <= r.v0;
        req_ch.old_dest_chunk <= r.old_dest;
        req_ch.unmasked       <= r.unmasked;
        req_ch.chunk_number   <= r.chunk;
        req_ch.last_chunk     <= r.last;
        do @(posedge clk); while (!req_ch.ready);
        requests_sent++;
        if (compute_mask_response(r, res)) awaited_responses.push_back(res);
    endtask

    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge clk);
        // requests with no response may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_vector_length(input logic [VL_W-1:0] len);
        wait_until_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= len;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        active_len = len;
        settings_used++;
    endtask

    task automatic check_logical_ops();
        // reset length is zero, so every bit is tail
        send_mask_request(make_request(MODE_XOR, '1, 64'h1234_5678_9ABC_DEF0,
                                       '0, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 4'd0, 1'b0));
        set_vector_length(VL_W'(100));
        for (int m = MODE_AND; m <= MODE_XNOR; m++) begin
            send_mask_request(make_request(MODE_W'(m), 64'hFF00_FF00_FF00_FF00,
                                           64'hF0F0_F0F0_F0F0_F0F0, '0,
                                           64'h5555_5555_5555_5555, m[0], 4'd1,
                                           m == MODE_XNOR));
        end
    endtask

    task automatic check_popcount_masking();
        send_mask_request(make_request(MODE_POPC, '0, '1, 64'h0000_FFFF_0000_FFFF,
                                       '0, 1'b0, 4'd0, 1'b0));
        send_mask_request(make_request(MODE_POPC, '1, '1, '0, '1, 1'b1, 4'd1, 1'b1));
    endtask

    task automatic check_find_first();
        // nothing set anywhere
        send_mask_request(make_request(MODE_FIRST, '1, '0, '1, '0, 1'b0, 4'd0, 1'b0));
        send_mask_request(make_request(MODE_FIRST, '1, '0, '1, '0, 1'b1, 4'd1, 1'b1));
        // hit hidden by v0, then a real hit, then a lower one that must be ignored
        send_mask_request(make_request(MODE_FIRST, '0, 64'h20, 64'hFFDF, '0, 1'b0, 4'd0,
                                       1'b0));
        send_mask_request(make_request(MODE_FIRST, '0, 64'h0000_0100_0000_0008, '0, '0,
                                       1'b1, 4'd1, 1'b0));
        send_mask_request(make_request(MODE_FIRST, '0, 64'h1, '1, '0, 1'b1, 4'd0, 1'b1));
    endtask

    task automatic check_unused_modes();
        send_mask_request(make_request(MODE_POPC, '0, '1, '0, '0, 1'b1, 4'd0, 1'b0));
        send_mask_request(make_request(MODE_TOP, '1, '1, '1, '1, 1'b1, 4'd3, 1'b0));
        // an ignored last chunk still clears the running count
        send_mask_request(make_request(MODE_FIRST + 4'd3, '1, '1, '1, '1, 1'b0, 4'd0, 1'b1));
        send_mask_request(make_request(MODE_POPC, '0, '1, '0, '0, 1'b1, 4'd1, 1'b1));
    endtask

    task automatic check_length_extremes();
        set_vector_length('0);
        send_mask_request(make_request(MODE_XNOR, '0, '0, '0, 64'hDEAD_BEEF_0123_4567,
                                       1'b1, 4'd0, 1'b0));
        send_mask_request(make_request(MODE_POPC, '0, '1, '1, '0, 1'b1, 4'd0, 1'b1));
        // above the register size acts as the full size
        set_vector_length('1);
        send_mask_request(make_request(MODE_XNOR, '0, '0, '0, '0, 1'b0, 4'd15, 1'b0));
        send_mask_request(make_request(MODE_FIRST, '0, 64'h8000_0000_0000_0000, '0, '0,
                                       1'b1, 4'd15, 1'b1));
    endtask

    task automatic check_count_saturation();
        set_vector_length(VL_W'(MAX_MASK_BITS));
        for (int i = 0; i < 20; i++) begin
            send_mask_request(make_request(MODE_POPC, rand_word(), '1, rand_word(),
                                           rand_word(), 1'b1, CHUNK_NUM_W'(i), i == 19));
        end
    endtask

    function automatic t_mask_req random_single_request();
        t_mask_req r;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) r.mode = MODE_W'($urandom_range(MODE_AND, MODE_XNOR));
        else if (pick < 9) r.mode = MODE_W'($urandom_range(MODE_POPC, MODE_FIRST));
        else r.mode = MODE_W'($urandom_range(MODE_FIRST + 1, MODE_TOP));
        r.vs1 = rand_word();
        r.vs2 = rand_word();
        r.v0 = rand_word();
        r.old_dest = rand_word();
        r.unmasked = 1'($urandom_range(0, 1));
        r.chunk = CHUNK_NUM_W'($urandom_range(0, 15));
        r.last = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Output held off for a long stretch while requests keep coming.
    task automatic check_output_backpressure();
        idle_on <= 1'b0;
        hold_ask <= 1'b1;
        for (int i = 0; i < 30; i++) send_mask_request(random_single_request());
        idle_on <= 1'b1;
    endtask

    // Mostly well-formed popcount / find-first scans, plus single ops and noise.
    task automatic run_random_traffic(input int unsigned n_items);
        int unsigned counted;
        int unsigned len;
        int unsigned start;
        logic [MODE_W-1:0] scan_mode;
        logic scan_unmasked;
        t_mask_req r;
        counted = 0;
        while (counted < n_items) begin
            if ($urandom_range(0, 9) < 5) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16)
                                                  : $urandom_range(1, 4);
                start = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
                scan_mode = $urandom_range(0, 1) ? MODE_POPC : MODE_FIRST;
                scan_unmasked = 1'($urandom_range(0, 1));
                for (int i = 0; i < len; i++) begin
                    r = random_single_request();
                    r.mode = scan_mode;
                    r.unmasked = scan_unmasked;
                    r.chunk = CHUNK_NUM_W'(start + i);
                    r.last = (i == len - 1);
                    // sparse sources so the first hit lands at varied chunks
                    if (scan_mode == MODE_FIRST && $urandom_range(0, 1)) r.vs2 = '0;
                    send_mask_request(r);
                    counted++;
                end
            end else begin
                r = random_single_request();
                send_mask_request(r);
                if (r.mode <= MODE_FIRST) counted++;
            end
        end
    endtask

    task automatic check_random_traffic();
        logic [VL_W-1:0] lengths[8];
        lengths = '{VL_W'(MAX_MASK_BITS), VL_W'(64), '1, VL_W'(1), VL_W'(0), VL_W'(777),
                    VL_W'(65), VL_W'(1000)};
        lengths[5] = VL_W'($urandom_range(2, MAX_MASK_BITS));
        for (int p = 0; p < 8; p++) begin
            set_vector_length(lengths[p]);
            idle_on <= (p % 3 != 2);
            run_random_traffic(RANDOM_PHASE);
        end
        idle_on <= 1'b1;
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = '0;
        req_ch.first_chunk = '0;
        req_ch.second_chunk = '0;
        req_ch.mask_chunk = '0;
        req_ch.old_dest_chunk = '0;
        req_ch.unmasked = 1'b0;
        req_ch.chunk_number = '0;
        req_ch.last_chunk = 1'b0;
        rsp_ch.ready = 1'b1;
        rsp_gap = 0;
        hold_ask = 1'b0;
        idle_on = 1'b1;
        cycle_count = 0;
        mismatch_count = 0;
        requests_sent = 0;
        responses_checked = 0;
        settings_used = 0;
        active_len = '0;
        pop_total = 0;
        first_found = 1'b0;
        first_pos = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        check_logical_ops();
        check_popcount_masking();
        check_find_first();
        check_unused_modes();
        check_length_extremes();
        check_count_saturation();
        check_output_backpressure();
        check_random_traffic();
        wait_until_drained();

        $display("Sent %0d requests and checked %0d responses across %0d vector lengths,",
                 requests_sent, responses_checked, settings_used);
        $display("covering all logical ops, popcount, find-first, tail bits and stalls.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> vector_mask_unit.f
+incdir+rtl
rtl/vmu_pkg.sv
rtl/vmu_if.sv
rtl/vmu_lane.sv
rtl/vmu_merge.sv
rtl/vector_mask_unit.sv
tb/testbench.sv
